/* rtl/header_framed_led_frame_deframer_core_assert.svh */
// Assertion macros for the LED frame deframer checker.
// Expects clk and rst_n in the scope of use.
`ifndef HEADER_FRAMED_LED_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define HEADER_FRAMED_LED_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication.
`define HFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hfd_pkg.sv */
// Shared types, constants and functions for the LED frame deframer.
// No dependencies.
package hfd_pkg;

    localparam int PIX_DEFAULT = 32;
    localparam int PIX_MAX     = 64;
    localparam int ADDR_MAX_W  = 6;      // word address width at PIX_MAX
    localparam int HDR_LEN     = 15;
    localparam int CNT_W       = 11;
    localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

    // Write request into the pixel staging RAM: one byte lane of one pixel word.
    typedef struct packed {
        logic                  en;
        logic [ADDR_MAX_W-1:0] addr;
        logic [1:0]            lane;
        logic [7:0]            data;
    } stage_wr_t;

    // Header text, one byte per position.
    function automatic logic [7:0] hdr_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h6d;
            4'd1:    c = 8'h75;
            4'd2:    c = 8'h6c;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h69;
            4'd5:    c = 8'h76;
            4'd6:    c = 8'h65;
            4'd7:    c = 8'h72;
            4'd8:    c = 8'h73;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h3a;
            4'd11:   c = 8'h64;
            4'd12:   c = 8'h61;
            4'd13:   c = 8'h74;
            4'd14:   c = 8'h61;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // br * 31 / 255 via reciprocal: x/255 == (x + (x >> 8) + 1) >> 8 for x < 65535.
    function automatic logic [4:0] br_scale(input logic [7:0] br);
        logic [12:0] prod;
        logic [15:0] sum;
        prod = 13'(br) * 13'd31;
        sum  = 16'(prod) + 16'(prod >> 8) + 16'd1;
        return sum[12:8];
    endfunction

    // Nonzero and a whole number of pixels.
    function automatic logic frame_ok(input logic [CNT_W-1:0] len);
        return (len != '0) && (len[1:0] == 2'b00);
    endfunction

endpackage

/* rtl/hfd_stage_ram.sv */
// Pixel staging RAM: one 4-byte word per pixel, byte-lane writes, registered read.
// Depends on hfd_pkg.
module hfd_stage_ram
    import hfd_pkg::*;
#(
    parameter  int PIXELS = PIX_DEFAULT,
    localparam int IDX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1
)
(
    input  logic                 clk,
    input  stage_wr_t            wr,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [3:0][7:0]      rd_data
);

    logic [3:0][7:0] mem [PIXELS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[IDX_W-1:0]][wr.lane] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/header_framed_led_frame_deframer_core.sv */
// Readout: a committing byte starts readout of the staged frame; each pixel takes a RAM read,
//   then a load of the output register, PIXELS pixels per commit.
// Throughput: one byte per cycle between commits; input stalls while the committed frame is
//   read out, longer if the output side stalls. The alternating RAM read and output load set this.
// Reset: async active low; hunting, header match and payload count cleared, RAM not cleared.
module header_framed_led_frame_deframer_core
    import hfd_pkg::*;
#(
    parameter int PIXELS = PIX_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    // byte input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       chunk_end,
    // pixel output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] pixel_index,
    output logic [7:0] blue,
    output logic [7:0] green,
    output logic [7:0] red,
    output logic [4:0] brightness,
    output logic       last_pixel
);

    localparam int IDX_W       = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int NPIX_W      = $clog2(PIXELS + 1);
    localparam int EXT_W       = (IDX_W > 5) ? IDX_W : 5;
    localparam int STAGE_BYTES = PIXELS * 4;

    typedef enum logic [1:0] {
        ST_IDLE,   // taking bytes
        ST_RD,     // RAM read of pixel idx in flight
        ST_LD      // RAM data ready, load output register
    } state_t;

    state_t             state_reg, state_next;
    logic [3:0]         hmc_reg, hmc_next;          // header bytes matched
    logic               in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]   pc_reg, pc_next;            // payload bytes since header
    logic [IDX_W-1:0]   idx_reg, idx_next;          // pixel being read out
    logic [NPIX_W-1:0]  npix_reg, npix_next;        // received pixels in committed frame

    logic               out_valid_reg, out_valid_next;
    logic [4:0]         pixel_index_reg, pixel_index_next;
    logic [7:0]         blue_reg, blue_next;
    logic [7:0]         green_reg, green_next;
    logic [7:0]         red_reg, red_next;
    logic [4:0]         brightness_reg, brightness_next;
    logic               last_pixel_reg, last_pixel_next;

    // Per-byte step results
    logic [3:0]         m0, m1;
    logic               completed;
    logic [CNT_W-1:0]   len_hdr, pc_upd, emit_len;
    logic               if_upd, fire_hdr, fire_end, drop, fire;
    logic [3:0]         hmc_step;
    logic               if_step;
    logic [CNT_W-1:0]   pc_step;
    logic [8:0]         quads;
    logic [NPIX_W-1:0]  npix_emit;

    // RAM ports
    stage_wr_t          wr;
    logic               rd_en;
    logic [3:0][7:0]    rd_data;

    logic               take;
    logic               pix_live;
    logic [EXT_W-1:0]   idx_ext;
    logic               idx_last;

    assign take     = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);

    // Header hunt and payload bookkeeping for the byte on the input.
    always_comb
    begin
        m0 = (hmc_reg >= 4'(HDR_LEN)) ? 4'd0 : hmc_reg;
        if (data_byte == hdr_char(m0))
        begin
            m1 = m0 + 4'd1;
        end
        else
        begin
            // first header byte appears nowhere else, so restart at 0 or 1
            m1 = (data_byte == hdr_char(4'd0)) ? 4'd1 : 4'd0;
        end
        completed = (m1 == 4'(HDR_LEN));

        // the header's first 14 bytes were counted as payload; take them back
        len_hdr  = (pc_reg >= CNT_W'(HDR_LEN - 1)) ? pc_reg - CNT_W'(HDR_LEN - 1) : '0;
        fire_hdr = completed && in_frame_reg && frame_ok(len_hdr);

        if (completed)
        begin
            pc_upd = '0;
        end
        else if (in_frame_reg && (pc_reg < CNT_MAX))
        begin
            pc_upd = pc_reg + CNT_W'(1);
        end
        else
        begin
            pc_upd = pc_reg;
        end
        if_upd = completed || in_frame_reg;

        fire_end = chunk_end && if_upd && !fire_hdr && frame_ok(pc_upd);
        drop     = chunk_end && if_upd && !fire_hdr && !frame_ok(pc_upd)
                   && (pc_upd > CNT_W'(HDR_LEN));
        fire     = fire_hdr || fire_end;
        emit_len = fire_hdr ? len_hdr : pc_upd;

        hmc_step = (fire_end || completed) ? 4'd0 : m1;
        if_step  = (fire_end || drop) ? 1'b0 : if_upd;
        pc_step  = (fire_end || drop) ? '0 : pc_upd;

        // pixel count, capped at PIXELS
        quads     = emit_len[CNT_W-1:2];
        npix_emit = (quads > 9'(PIXELS)) ? NPIX_W'(PIXELS) : NPIX_W'(quads);

        // stage payload bytes up to the cap
        wr.en   = take && !completed && in_frame_reg && (pc_reg < CNT_W'(STAGE_BYTES));
        wr.addr = ADDR_MAX_W'(pc_reg >> 2);
        wr.lane = pc_reg[1:0];
        wr.data = data_byte;
    end

    hfd_stage_ram #(
        .PIXELS (PIXELS)
    ) u_stage_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign idx_ext  = EXT_W'(idx_reg);
    assign idx_last = (idx_reg == IDX_W'(PIXELS - 1));
    assign pix_live = (NPIX_W'(idx_reg) < npix_reg);

    // Sequencer: byte intake, then readout of the committed frame.
    always_comb
    begin
        state_next       = state_reg;
        hmc_next         = hmc_reg;
        in_frame_next    = in_frame_reg;
        pc_next          = pc_reg;
        idx_next         = idx_reg;
        npix_next        = npix_reg;
        rd_en            = 1'b0;
        out_valid_next   = out_valid_reg && out_stall;
        pixel_index_next = pixel_index_reg;
        blue_next        = blue_reg;
        green_next       = green_reg;
        red_next         = red_reg;
        brightness_next  = brightness_reg;
        last_pixel_next  = last_pixel_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    hmc_next      = hmc_step;
                    in_frame_next = if_step;
                    pc_next       = pc_step;
                    if (fire)
                    begin
                        idx_next   = '0;
                        npix_next  = npix_emit;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_LD;
            end
            ST_LD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    pixel_index_next = idx_ext[4:0];
                    blue_next        = pix_live ? rd_data[0] : 8'd0;
                    green_next       = pix_live ? rd_data[1] : 8'd0;
                    red_next         = pix_live ? rd_data[2] : 8'd0;
                    brightness_next  = pix_live ? br_scale(rd_data[3]) : 5'd0;
                    last_pixel_next  = idx_last;
                    if (idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hmc_reg       <= '0;
            in_frame_reg  <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hmc_reg       <= hmc_next;
            in_frame_reg  <= in_frame_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Readout counters and output payload
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        npix_reg        <= npix_next;
        pixel_index_reg <= pixel_index_next;
        blue_reg        <= blue_next;
        green_reg       <= green_next;
        red_reg         <= red_next;
        brightness_reg  <= brightness_next;
        last_pixel_reg  <= last_pixel_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign blue        = blue_reg;
    assign green       = green_reg;
    assign red         = red_reg;
    assign brightness  = brightness_reg;
    assign last_pixel  = last_pixel_reg;

endmodule

/* rtl/hfd_checker.sv */
// Port-level checks for the LED frame deframer, bound to the top level.
// Depends on hfd_pkg and header_framed_led_frame_deframer_core_assert.svh.
`include "header_framed_led_frame_deframer_core_assert.svh"

module hfd_checker
    import hfd_pkg::*;
#(
    parameter int PIXELS = PIX_DEFAULT
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [4:0] pixel_index,
    input logic [7:0] blue,
    input logic [7:0] green,
    input logic [7:0] red,
    input logic [4:0] brightness,
    input logic       last_pixel
);

    localparam logic [4:0] LAST_IDX = 5'((PIXELS - 1) % 32);

    // stalled result holds
    `HFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_index) && $stable(blue) && $stable(green) && $stable(red) && $stable(brightness) && $stable(last_pixel), "stalled pixel changed")

    // no byte taken while a frame is still being read out
    `HFD_ASSERT_NOW(a_in_held, out_valid && !last_pixel, in_stall, "input taken mid-frame")

    // frame ends on the final pixel index
    `HFD_ASSERT_NOW(a_last_idx, out_valid && last_pixel, pixel_index == LAST_IDX, "bad last index")

endmodule

bind header_framed_led_frame_deframer_core hfd_checker #(
    .PIXELS (PIXELS)
) u_hfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_index (pixel_index),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .brightness  (brightness),
    .last_pixel  (last_pixel)
);
